@@ rtl/mcsl_pkg.sv @@
// shared constants, types and register map of the mc slope limiter stencil
package mcsl_pkg;

    // grid and field widths
    localparam int MAX_GRID_DEF = 1024;
    localparam int GS_W         = 11;
    localparam int GRID_MIN     = 3;
    localparam int CELL_W       = 10;
    localparam int SAMPLE_W     = 32;
    localparam int DIFF_W       = SAMPLE_W + 1;
    localparam int M_TDATA_W    = 88;
    localparam int M_PAD_W      = M_TDATA_W - 2 * CELL_W - 2 * SAMPLE_W;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [GS_W-1:0] GRID_SIZE_RESET = GS_W'(1024);

    // register index, taken from paddr[2]
    localparam logic REG_GRID_SIZE = 1'b0;

    // per-cell bookkeeping that follows a sample down the pipeline
    typedef struct packed {
        logic [CELL_W-1:0] row;     // row of the input sample
        logic [CELL_W-1:0] col;     // column of the input sample
        logic              emit;    // sample completes a cell
        logic              two;     // last row: border cell follows
        logic              border;  // completed cell lies on the border
    } cell_tag_t;

endpackage

@@ rtl/mcsl_line_store.sv @@
// two line memories holding the previous and the older grid row, plus the left tap
module mcsl_line_store #(
    parameter int MAX_GRID = mcsl_pkg::MAX_GRID_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // read request and sample write, issued when a sample is accepted
    input  logic                              rd_en,
    input  logic [$clog2(MAX_GRID)-1:0]       rd_col,
    input  logic [mcsl_pkg::SAMPLE_W-1:0]     wr_sample,
    // older row write, issued when the sample leaves the first stage
    input  logic                              older_wr_en,
    input  logic [$clog2(MAX_GRID)-1:0]       older_wr_col,
    // stencil taps of the sample in the first stage
    output logic [mcsl_pkg::SAMPLE_W-1:0]     center,
    output logic [mcsl_pkg::SAMPLE_W-1:0]     right,
    output logic [mcsl_pkg::SAMPLE_W-1:0]     up,
    output logic [mcsl_pkg::SAMPLE_W-1:0]     left
);

    localparam int CW = $clog2(MAX_GRID);

    logic [mcsl_pkg::SAMPLE_W-1:0] prev_mem  [MAX_GRID];
    logic [mcsl_pkg::SAMPLE_W-1:0] older_mem [MAX_GRID];

    logic [CW:0]                   right_sum;
    logic [CW-1:0]                 right_addr;
    logic [mcsl_pkg::SAMPLE_W-1:0] center_reg;
    logic [mcsl_pkg::SAMPLE_W-1:0] right_reg;
    logic [mcsl_pkg::SAMPLE_W-1:0] up_reg;
    logic [mcsl_pkg::SAMPLE_W-1:0] left_reg;

    // right neighbor address, kept inside the memory at the last column
    assign right_sum  = {1'b0, rd_col} + (CW+1)'(1);
    assign right_addr = (right_sum >= (CW+1)'(MAX_GRID)) ? '0 : right_sum[CW-1:0];

    // previous row: two reads and one write, old data on a same-address read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            center_reg       <= prev_mem[rd_col];
            right_reg        <= prev_mem[right_addr];
            prev_mem[rd_col] <= wr_sample;
        end
    end

    // older row: read at accept, written with the center on its way out
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            up_reg <= older_mem[rd_col];
        end
        if (older_wr_en) begin
            older_mem[older_wr_col] <= center_reg;
        end
    end

    // left tap is the center of the sample before
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= '0;
        end else if (older_wr_en) begin
            left_reg <= center_reg;
        end
    end

    assign center = center_reg;
    assign right  = right_reg;
    assign up     = up_reg;
    assign left   = left_reg;

endmodule

@@ rtl/mcsl_limiter.sv @@
// five-stage mc limiter for one direction: differences, magnitudes, min, saturation
module mcsl_limiter (
    input  logic                          aclk,
    input  logic [4:0]                    adv,
    input  logic [mcsl_pkg::SAMPLE_W-1:0] prv,
    input  logic [mcsl_pkg::SAMPLE_W-1:0] cur,
    input  logic [mcsl_pkg::SAMPLE_W-1:0] nxt,
    output logic [mcsl_pkg::SAMPLE_W-1:0] slope
);

    localparam int DW = mcsl_pkg::DIFF_W;
    localparam int SW = mcsl_pkg::SAMPLE_W;

    logic signed [DW-1:0] fwd_reg, bwd_reg;
    logic [DW-1:0]        a_reg, b_reg;
    logic                 neg_b_reg, zero_b_reg;
    logic [DW-1:0]        half_reg, mn_reg;
    logic                 neg_c_reg, zero_c_reg;
    logic [DW-1:0]        m_reg;
    logic                 neg_d_reg, zero_d_reg;
    logic [SW-1:0]        slope_reg;

    logic signed [DW-1:0] fwd_next, bwd_next;
    logic [DW:0]          sum;
    logic [DW:0]          twice_mn;
    logic [DW-1:0]        m_next;
    logic [SW-1:0]        slope_next;

    // exact forward and backward differences
    assign fwd_next = $signed({nxt[SW-1], nxt}) - $signed({cur[SW-1], cur});
    assign bwd_next = $signed({cur[SW-1], cur}) - $signed({prv[SW-1], prv});

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            fwd_reg <= fwd_next;
            bwd_reg <= bwd_next;
        end
    end

    // magnitudes and sign agreement
    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            a_reg      <= fwd_reg[DW-1] ? DW'(-fwd_reg) : DW'(fwd_reg);
            b_reg      <= bwd_reg[DW-1] ? DW'(-bwd_reg) : DW'(bwd_reg);
            neg_b_reg  <= fwd_reg[DW-1];
            zero_b_reg <= (fwd_reg == '0)
                       || (fwd_reg[DW-1] && !bwd_reg[DW-1] && bwd_reg != '0)
                       || (!fwd_reg[DW-1] && bwd_reg[DW-1]);
        end
    end

    // central average and smaller magnitude
    assign sum = {1'b0, a_reg} + {1'b0, b_reg};

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            half_reg   <= sum[DW:1];
            mn_reg     <= (a_reg < b_reg) ? a_reg : b_reg;
            neg_c_reg  <= neg_b_reg;
            zero_c_reg <= zero_b_reg;
        end
    end

    // min of twice the smaller magnitude and the average
    assign twice_mn = {mn_reg, 1'b0};
    assign m_next   = (twice_mn < {1'b0, half_reg}) ? twice_mn[DW-1:0] : half_reg;

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            m_reg      <= m_next;
            neg_d_reg  <= neg_c_reg;
            zero_d_reg <= zero_c_reg;
        end
    end

    // sign and saturation to 32 bits
    always_comb begin
        if (zero_d_reg) begin
            slope_next = '0;
        end else if (!neg_d_reg) begin
            slope_next = (m_reg > DW'({1'b0, {(SW-1){1'b1}}})) ? {1'b0, {(SW-1){1'b1}}}
                                                              : m_reg[SW-1:0];
        end else begin
            slope_next = (m_reg > DW'({1'b1, {(SW-1){1'b0}}})) ? {1'b1, {(SW-1){1'b0}}}
                                                              : SW'(-m_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            slope_reg <= slope_next;
        end
    end

    assign slope = slope_reg;

endmodule

@@ rtl/mcsl_out.sv @@
// output register that sends one or two results per completed cell
module mcsl_out (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    input  mcsl_pkg::cell_tag_t               in_tag,
    input  logic [mcsl_pkg::SAMPLE_W-1:0]     in_slope_row,
    input  logic [mcsl_pkg::SAMPLE_W-1:0]     in_slope_col,
    output logic                              load,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mcsl_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tlast
);

    localparam int CELL_W = mcsl_pkg::CELL_W;
    localparam int SW     = mcsl_pkg::SAMPLE_W;

    logic              valid_reg;
    logic              phase_reg;
    logic              two_reg;
    logic [CELL_W-1:0] row_reg;
    logic [CELL_W-1:0] col_reg;
    logic [SW-1:0]     sr_reg;
    logic [SW-1:0]     sc_reg;
    logic              last_beat;
    logic [CELL_W-1:0] row_out;
    logic [SW-1:0]     sr_out;
    logic [SW-1:0]     sc_out;

    assign last_beat = !two_reg || phase_reg;
    assign load      = !valid_reg || (m_tready && last_beat);

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= in_valid;
            phase_reg <= 1'b0;
        end else if (m_tready) begin
            phase_reg <= 1'b1;
        end
    end

    // payload, border cells get zero slopes
    always_ff @(posedge aclk) begin
        if (load) begin
            two_reg <= in_tag.two;
            row_reg <= in_tag.row;
            col_reg <= in_tag.col;
            sr_reg  <= in_tag.border ? '0 : in_slope_row;
            sc_reg  <= in_tag.border ? '0 : in_slope_col;
        end
    end

    // first request is the cell above, second the last-row border cell
    assign row_out = phase_reg ? row_reg : row_reg - CELL_W'(1);
    assign sr_out  = phase_reg ? '0 : sr_reg;
    assign sc_out  = phase_reg ? '0 : sc_reg;

    assign m_tvalid = valid_reg;
    assign m_tlast  = last_beat;
    assign m_tdata  = {{mcsl_pkg::M_PAD_W{1'b0}}, sc_out, sr_out, col_reg, row_out};

endmodule

@@ rtl/mc_slope_limiter_2d_stencil.sv @@
// top level of the 2d mc slope limiter stencil: counters, pipeline control, config port
// Takes one Q16.16 sample per cycle in raster order while the output does not stall, and
// emits the limited slopes of the cell one row above; each sample of the last row also
// emits that row's border cell, so the output register sends two results for it and
// takes no new sample until both have gone. A result passes the line memory read
// register, five limiter stages and the output register. Both rows live in MAX_GRID-word
// line memories with no clearing pass. grid_size is clamped to 3..MAX_GRID, and the user
// must see that it is written only while the block is idle; the block does not enforce this.
module mc_slope_limiter_2d_stencil #(
    parameter int MAX_GRID = mcsl_pkg::MAX_GRID_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // sample stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mcsl_pkg::SAMPLE_W-1:0]       s_tdata,   // [31:0] sample
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [9:0] cell_row, [19:10] cell_col, [51:20] slope_row_dir, [83:52] slope_col_dir
    output logic [mcsl_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast,   // last_of_run
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mcsl_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [mcsl_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [mcsl_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int CW     = $clog2(MAX_GRID);
    localparam int NLOG   = $clog2(MAX_GRID + 1);
    localparam int NW     = (NLOG > mcsl_pkg::GS_W) ? NLOG : mcsl_pkg::GS_W;
    localparam int GS_W   = mcsl_pkg::GS_W;
    localparam int SW     = mcsl_pkg::SAMPLE_W;
    localparam int CELL_W = mcsl_pkg::CELL_W;

    logic [GS_W-1:0]     grid_size_reg;
    logic [CW-1:0]       row_reg, row_next;
    logic [CW-1:0]       col_reg, col_next;
    logic [NW-1:0]       gs_ext, n_eff, n_m1;
    logic [CW-1:0]       row_eff, col_eff;
    logic                col_last, row_last;
    logic                accept;
    mcsl_pkg::cell_tag_t tag0;

    logic [7:1]          load;
    logic                out_load;
    logic [6:1]          valid_reg;
    mcsl_pkg::cell_tag_t tag_reg [6:1];
    logic [SW-1:0]       sample1_reg;
    logic [CW-1:0]       col1_reg;

    logic [SW-1:0]       center, right, up, left;
    logic [SW-1:0]       slope_row, slope_col;

    // configuration register, single word at address zero
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_size_reg <= mcsl_pkg::GRID_SIZE_RESET;
        end else if (psel && penable && pwrite && paddr[2] == mcsl_pkg::REG_GRID_SIZE) begin
            grid_size_reg <= pwdata[GS_W-1:0];
        end
    end

    assign prdata = (paddr[2] == mcsl_pkg::REG_GRID_SIZE)
                  ? mcsl_pkg::APB_DATA_W'(grid_size_reg) : '0;

    // effective grid size
    assign gs_ext = NW'(grid_size_reg);

    always_comb begin
        if (gs_ext < NW'(mcsl_pkg::GRID_MIN)) begin
            n_eff = NW'(mcsl_pkg::GRID_MIN);
        end else if (gs_ext > NW'(MAX_GRID)) begin
            n_eff = NW'(MAX_GRID);
        end else begin
            n_eff = gs_ext;
        end
    end

    assign n_m1 = n_eff - NW'(1);

    // raster position, wrapped when the size shrank
    assign col_eff  = (NW'(col_reg) >= n_eff) ? '0 : col_reg;
    assign row_eff  = (NW'(row_reg) >= n_eff) ? '0 : row_reg;
    assign col_last = (NW'(col_eff) == n_m1);
    assign row_last = (NW'(row_eff) == n_m1);

    always_comb begin
        row_next = row_eff;
        col_next = col_eff + CW'(1);
        if (col_last) begin
            col_next = '0;
            row_next = row_last ? '0 : row_eff + CW'(1);
        end
    end

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
        end else if (accept) begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // what this sample completes
    always_comb begin
        tag0.row    = CELL_W'(row_eff);
        tag0.col    = CELL_W'(col_eff);
        tag0.emit   = (row_eff != '0);
        tag0.two    = row_last;
        tag0.border = !((row_eff >= CW'(2)) && (col_eff != '0) && (NW'(col_eff) < n_m1));
    end

    // stage loads, a stage takes new data when empty or when it drains
    always_comb begin
        load[7] = out_load;
        for (int k = 6; k >= 1; k--) begin
            load[k] = !valid_reg[k] || load[k+1];
        end
    end

    assign s_tready = load[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (load[1]) begin
                valid_reg[1] <= s_tvalid;
            end
            for (int k = 2; k <= 6; k++) begin
                if (load[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // sideband pipeline
    always_ff @(posedge aclk) begin
        if (load[1]) begin
            tag_reg[1]  <= tag0;
            sample1_reg <= s_tdata;
            col1_reg    <= col_eff;
        end
        for (int k = 2; k <= 6; k++) begin
            if (load[k]) begin
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    // line memories
    mcsl_line_store #(
        .MAX_GRID (MAX_GRID)
    ) u_line_store (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .rd_en        (accept),
        .rd_col       (col_eff),
        .wr_sample    (s_tdata),
        .older_wr_en  (valid_reg[1] && load[2]),
        .older_wr_col (col1_reg),
        .center       (center),
        .right        (right),
        .up           (up),
        .left         (left)
    );

    // slope along the row index
    mcsl_limiter u_limiter_row (
        .aclk  (aclk),
        .adv   (load[6:2]),
        .prv   (up),
        .cur   (center),
        .nxt   (sample1_reg),
        .slope (slope_row)
    );

    // slope along the column index
    mcsl_limiter u_limiter_col (
        .aclk  (aclk),
        .adv   (load[6:2]),
        .prv   (left),
        .cur   (center),
        .nxt   (right),
        .slope (slope_col)
    );

    // output register
    mcsl_out u_out (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (valid_reg[6] && tag_reg[6].emit),
        .in_tag       (tag_reg[6]),
        .in_slope_row (slope_row),
        .in_slope_col (slope_col),
        .load         (out_load),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

endmodule

@@ test/testbench.sv @@
// self-checking testbench for the 2d mc slope limiter stencil
`timescale 1ns / 1ps

module testbench;
    import mcsl_pkg::*;

    localparam int GRID_CAP     = MAX_GRID_DEF;
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int PHASE_ITEMS  = 325;

    // one slope result as it leaves the block
    typedef struct {
        logic [CELL_W-1:0]   row;
        logic [CELL_W-1:0]   col;
        logic [SAMPLE_W-1:0] slope_row;
        logic [SAMPLE_W-1:0] slope_col;
        logic                last;
    } slope_result_t;

    // sample content styles
    typedef enum int {
        FILL_RANDOM,
        FILL_NEAR_ZERO,
        FILL_EXTREME,
        FILL_RAMP,
        FILL_MIXED
    } fill_style_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [SAMPLE_W-1:0]   s_tdata = '0;     // [31:0] sample
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // [9:0] row, [19:10] col, [51:20] slope_row_dir, [83:52] slope_col_dir
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;          // last_of_run
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    mc_slope_limiter_2d_stencil DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // stimulus and expectation stores
    logic [SAMPLE_W-1:0] sample_queue[$];
    slope_result_t       slope_queue[$];
    int                  pushed_cnt = 0;
    int                  accepted_cnt = 0;
    int                  checked_cnt = 0;
    int                  error_cnt = 0;
    int                  cycle_cnt = 0;
    int                  grid_cnt = 0;
    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;
    bit                  in_accepted = 1'b0;

    // shadow of the stencil state
    int                  grid_n = GRID_CAP;
    bit signed [31:0]    prev_row [GRID_CAP];
    bit signed [31:0]    old_row [GRID_CAP];
    bit signed [31:0]    left_val = 0;
    int                  row_pos = 0;
    int                  col_pos = 0;

    // mc limited slope of one direction, saturated to 32 bits
    function automatic logic signed [31:0] limited_slope(input logic signed [31:0] prv,
                                                         input logic signed [31:0] cur,
                                                         input logic signed [31:0] nxt);
        longint fwd, bwd, a, b, m, h;
        fwd = longint'(nxt) - longint'(cur);
        bwd = longint'(cur) - longint'(prv);
        if ((fwd < 0 && bwd > 0) || (fwd > 0 && bwd < 0) || fwd == 0)
            return '0;
        a = (fwd < 0) ? -fwd : fwd;
        b = (bwd < 0) ? -bwd : bwd;
        m = 2 * a;
        if (2 * b < m)
            m = 2 * b;
        h = (a + b) / 2;
        if (h < m)
            m = h;
        if (fwd < 0)
            m = -m;
        if (m > 64'sd2147483647)
            m = 64'sd2147483647;
        if (m < -64'sd2147483648)
            m = -64'sd2147483648;
        return m[31:0];
    endfunction

    // advance the shadow stencil by one sample and queue the cells it completes
    task automatic predict_slopes(input logic signed [31:0] s);
        int               r, c;
        bit signed [31:0] center, right_val, up_val;
        slope_result_t    res;
        if (col_pos >= grid_n)
            col_pos = 0;
        if (row_pos >= grid_n)
            row_pos = 0;
        r = row_pos;
        c = col_pos;
        center = prev_row[c];
        right_val = (c + 1 < GRID_CAP) ? prev_row[c + 1] : 0;
        up_val = old_row[c];
        if (r >= 1) begin
            res.row = CELL_W'(r - 1);
            res.col = CELL_W'(c);
            res.slope_row = '0;
            res.slope_col = '0;
            if (r - 1 >= 1 && r - 1 < grid_n - 1 && c >= 1 && c < grid_n - 1) begin
                res.slope_row = limited_slope(up_val, center, s);
                res.slope_col = limited_slope(left_val, center, right_val);
            end
            res.last = (r != grid_n - 1);
            slope_queue.push_back(res);
            // last row also closes its own border cell
            if (r == grid_n - 1) begin
                res.row = CELL_W'(r);
                res.slope_row = '0;
                res.slope_col = '0;
                res.last = 1'b1;
                slope_queue.push_back(res);
            end
        end
        left_val = center;
        old_row[c] = center;
        prev_row[c] = s;
        if (c + 1 >= grid_n) begin
            col_pos = 0;
            row_pos = (r + 1 >= grid_n) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endtask

    // sample driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_accepted) begin
            if (sample_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_tdata <= sample_queue.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // monitor: predict on accepted samples, check accepted results
    always @(posedge aclk) begin
        slope_result_t want, got;
        cycle_cnt++;
        in_accepted = aresetn && s_tvalid && s_tready;
        if (in_accepted) begin
            predict_slopes(s_tdata);
            accepted_cnt++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            got.row = m_tdata[9:0];
            got.col = m_tdata[19:10];
            got.slope_row = m_tdata[51:20];
            got.slope_col = m_tdata[83:52];
            got.last = m_tlast;
            checked_cnt++;
            if (slope_queue.size() == 0) begin
                $display("%0t: unexpected result row %0d col %0d", $time, got.row, got.col);
                error_cnt++;
            end else begin
                want = slope_queue.pop_front();
                if (got.row !== want.row) begin
                    $display("%0t: cell_row expected %0d got %0d", $time, want.row, got.row);
                    error_cnt++;
                end
                if (got.col !== want.col) begin
                    $display("%0t: cell_col expected %0d got %0d", $time, want.col, got.col);
                    error_cnt++;
                end
                if (got.slope_row !== want.slope_row) begin
                    $display("%0t: slope_row_dir at (%0d,%0d) expected %h got %h", $time,
                             want.row, want.col, want.slope_row, got.slope_row);
                    error_cnt++;
                end
                if (got.slope_col !== want.slope_col) begin
                    $display("%0t: slope_col_dir at (%0d,%0d) expected %h got %h", $time,
                             want.row, want.col, want.slope_col, got.slope_col);
                    error_cnt++;
                end
                if (got.last !== want.last) begin
                    $display("%0t: last_of_run at (%0d,%0d) expected %0b got %0b", $time,
                             want.row, want.col, want.last, got.last);
                    error_cnt++;
                end
            end
        end
    end

    // watchdog
    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("testbench: done, errors");
        $finish;
    end

    function automatic logic [31:0] make_sample(input fill_style_t style, input int r,
                                                input int c, input int base);
        fill_style_t pick;
        pick = style;
        if (style == FILL_MIXED)
            pick = fill_style_t'($urandom_range(0, 3));
        case (pick)
            FILL_NEAR_ZERO: begin
                return 32'($urandom_range(0, 8)) - 32'd4;
            end
            FILL_EXTREME: begin
                case ($urandom_range(0, 4))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'hffff_ffff;
                    3: return 32'h0000_0001;
                    default: return 32'h0000_0000;
                endcase
            end
            FILL_RAMP: begin
                return 32'(base + r * 3000 - c * 1700 + int'($urandom_range(0, 600)) - 300);
            end
            default: begin
                return $urandom();
            end
        endcase
    endfunction

    task automatic queue_sample(input logic [31:0] value);
        sample_queue.push_back(value);
        pushed_cnt++;
    endtask

    // one grid of rows x n samples in raster order
    task automatic queue_grid(input int n, input int rows, input fill_style_t style);
        int base;
        base = $urandom();
        for (int r = 0; r < rows; r++)
            for (int c = 0; c < n; c++)
                queue_sample(make_sample(style, r, c, base));
        grid_cnt++;
    endtask

    // wait until every sample is taken and every result has come back
    task automatic wait_idle();
        while (accepted_cnt != pushed_cnt || slope_queue.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // register write: setup then access phase
    task automatic write_grid_size(input logic [GS_W-1:0] raw);
        @(negedge aclk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {REG_GRID_SIZE, 2'b00};
        pwdata = APB_DATA_W'(raw);
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        grid_n = (raw < GRID_MIN) ? GRID_MIN : (raw > GRID_CAP) ? GRID_CAP : int'(raw);
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // run sequence
    initial begin
        logic [31:0]    directed_grid [0:26];
        int             phase_items, raw_size, pick;
        int             idle_send [4];
        int             idle_recv [4];
        for (int i = 0; i < GRID_CAP; i++) begin
            prev_row[i] = 0;
            old_row[i] = 0;
        end
        idle_send = '{0, 69, 0, 26};
        idle_recv = '{0, 0, 69, 26};
        // interior cell: half-sum at both extremes / twice-bwd with bwd zero / twice-fwd and
        // opposite signs
        directed_grid = '{
            32'd1, 32'h8000_0000, 32'd5,
            32'h7fff_ffff, 32'd0, 32'h8000_0000,
            32'd7, 32'h7fff_ffff, 32'hffff_fffd,
            32'hffff_ffff, 32'd10, 32'd0,
            32'd20, 32'd20, 32'd50,
            32'd0, 32'd100, 32'd0,
            32'd3, 32'(-100), 32'(-32767),
            32'd0, 32'(-200), 32'd0,
            32'h7fff_ffff, 32'(-210), 32'h8000_0000
        };

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: below-minimum size clamps to 3, three grids back to back
        write_grid_size(GS_W'(0));
        foreach (directed_grid[i])
            queue_sample(directed_grid[i]);
        grid_cnt += 3;
        wait_idle();

        // random grids under each idling pattern
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = idle_send[p];
            recv_stall_pct = idle_recv[p];
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    raw_size = $urandom_range(0, 2);
                else if (pick < 3)
                    raw_size = $urandom_range(14, 22);
                else
                    raw_size = $urandom_range(3, 9);
                write_grid_size(GS_W'(raw_size));
                queue_grid(grid_n, grid_n, fill_style_t'($urandom_range(0, 4)));
                phase_items += grid_n * grid_n;
                wait_idle();
            end
        end

        $display("summary: %0d samples over %0d grids, sizes 3 to 22, four idling patterns",
                 accepted_cnt, grid_cnt);
        $display("summary: %0d slope results checked, %0d mismatches", checked_cnt, error_cnt);
        if (error_cnt == 0 && slope_queue.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
